>>> design/bmhq_pkg.sv
package bmhq_pkg;

  // Fixed field widths
  localparam int unsigned KEY_W = 32;
  localparam int unsigned CAP_W = 9;
  localparam int unsigned OCC_W = 9;

  // Parameter defaults
  localparam int unsigned DEPTH_DEF       = 256;
  localparam int unsigned HANDLE_BITS_DEF = 9;

  // Capacity register after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Action codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_DN_ROOT,
    ST_DN_LAST,
    ST_DN_LEFT,
    ST_DN_RIGHT,
    ST_PLACE,
    ST_DONE
  } state_e;

endpackage

>>> design/bmhq_mem.sv
module bmhq_mem #(
  parameter int unsigned DEPTH = bmhq_pkg::DEPTH_DEF,
  parameter int unsigned DW    = bmhq_pkg::KEY_W + bmhq_pkg::HANDLE_BITS_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/bmhq_ctrl.sv
module bmhq_ctrl #(
  parameter int unsigned DEPTH       = bmhq_pkg::DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = bmhq_pkg::HANDLE_BITS_DEF,
  localparam int unsigned AW    = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned CMP_W = (CNT_W > bmhq_pkg::CAP_W) ? CNT_W : bmhq_pkg::CAP_W,
  localparam int unsigned DW    = bmhq_pkg::KEY_W + HANDLE_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // item request
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      action_i,
  input  logic [DW-1:0]             entry_i,
  input  logic [CMP_W-1:0]          eff_cap_i,
  // result
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic                      res_ok_o,
  output logic [DW-1:0]             res_entry_o,
  output logic [CNT_W-1:0]          count_o,
  // memory port
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [DW-1:0]             mem_wdata_o,
  output logic                      mem_re_o,
  output logic [AW-1:0]             mem_raddr_o,
  input  logic [DW-1:0]             mem_rdata_i
);

  localparam int unsigned KW = bmhq_pkg::KEY_W;

  bmhq_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] hole_q, hole_d;
  logic [DW-1:0]    elem_q, elem_d;
  logic [DW-1:0]    child_q, child_d;
  logic [DW-1:0]    res_q, res_d;
  logic             res_ok_q, res_ok_d;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bmhq_pkg::ST_IDLE;
      cnt_q    <= '0;
      res_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      res_ok_q <= res_ok_d;
    end
  end

  // Working entries and position
  always_ff @(posedge clk_i) begin
    hole_q  <= hole_d;
    elem_q  <= elem_d;
    child_q <= child_d;
    res_q   <= res_d;
  end

  // Sequencer: hole-based sift, the moving entry stays in elem_q until placed
  always_comb begin
    logic [CNT_W-1:0] hole_m1;
    logic [CNT_W-1:0] parent;
    logic [CNT_W-1:0] cnt_p1;
    logic [CNT_W:0]   twoh;
    logic [CNT_W:0]   twoh1;
    logic [CNT_W:0]   twoc;
    logic [CNT_W:0]   cnt_x;
    logic [CNT_W-1:0] cpos;
    logic [DW-1:0]    cand;
    logic             step;
    logic             right_lt;

    state_d     = state_q;
    cnt_d       = cnt_q;
    hole_d      = hole_q;
    elem_d      = elem_q;
    child_d     = child_q;
    res_d       = res_q;
    res_ok_d    = res_ok_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = elem_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    step        = 1'b0;
    cand        = mem_rdata_i;

    hole_m1  = hole_q - 1'b1;
    parent   = hole_q >> 1;
    cnt_p1   = cnt_q + 1'b1;
    twoh     = {hole_q, 1'b0};
    twoh1    = twoh + 1'b1;
    cnt_x    = {1'b0, cnt_q};
    cpos     = twoh[CNT_W-1:0];
    right_lt = mem_rdata_i[KW-1:0] < child_q[KW-1:0];

    unique case (state_q)
      bmhq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          res_d    = '0;
          res_ok_d = 1'b0;
          if (action_i == bmhq_pkg::ACT_ENQ) begin
            if (CMP_W'(cnt_q) >= eff_cap_i) begin
              state_d = bmhq_pkg::ST_DONE;
            end else begin
              cnt_d    = cnt_p1;
              hole_d   = cnt_p1;
              elem_d   = entry_i;
              res_ok_d = 1'b1;
              if (cnt_q == '0) begin
                state_d = bmhq_pkg::ST_PLACE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AW'((cnt_p1 >> 1) - 1'b1);
                state_d     = bmhq_pkg::ST_UP_CMP;
              end
            end
          end else begin
            if (cnt_q == '0) begin
              state_d = bmhq_pkg::ST_DONE;
            end else begin
              cnt_d       = cnt_q - 1'b1;
              res_ok_d    = 1'b1;
              mem_re_o    = 1'b1;
              mem_raddr_o = '0;
              state_d     = bmhq_pkg::ST_DN_ROOT;
            end
          end
        end
      end
      bmhq_pkg::ST_UP_CMP: begin
        // parent entry is on the read port
        if (elem_q[KW-1:0] < mem_rdata_i[KW-1:0]) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = hole_m1[AW-1:0];
          mem_wdata_o = mem_rdata_i;
          hole_d      = parent;
          if (parent > CNT_W'(1)) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = AW'((parent >> 1) - 1'b1);
          end else begin
            state_d = bmhq_pkg::ST_PLACE;
          end
        end else begin
          state_d = bmhq_pkg::ST_PLACE;
        end
      end
      bmhq_pkg::ST_DN_ROOT: begin
        // capture the minimum, fetch the tail entry
        res_d = mem_rdata_i;
        if (cnt_q == '0) begin
          state_d = bmhq_pkg::ST_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = cnt_q[AW-1:0];
          state_d     = bmhq_pkg::ST_DN_LAST;
        end
      end
      bmhq_pkg::ST_DN_LAST: begin
        elem_d = mem_rdata_i;
        hole_d = CNT_W'(1);
        if (cnt_x >= (CNT_W + 1)'(2)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(1);
          state_d     = bmhq_pkg::ST_DN_LEFT;
        end else begin
          state_d = bmhq_pkg::ST_PLACE;
        end
      end
      bmhq_pkg::ST_DN_LEFT: begin
        child_d = mem_rdata_i;
        if (twoh1 <= cnt_x) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = twoh[AW-1:0];
          state_d     = bmhq_pkg::ST_DN_RIGHT;
        end else begin
          step = 1'b1;
          cand = mem_rdata_i;
          cpos = twoh[CNT_W-1:0];
        end
      end
      bmhq_pkg::ST_DN_RIGHT: begin
        // right child wins only when strictly smaller
        step = 1'b1;
        cand = right_lt ? mem_rdata_i : child_q;
        cpos = right_lt ? twoh1[CNT_W-1:0] : twoh[CNT_W-1:0];
      end
      bmhq_pkg::ST_PLACE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = hole_m1[AW-1:0];
        mem_wdata_o = elem_q;
        state_d     = bmhq_pkg::ST_DONE;
      end
      bmhq_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = bmhq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bmhq_pkg::ST_IDLE;
      end
    endcase

    // One sift-down level: move the smaller child up, or place the entry
    twoc = {cpos, 1'b0};
    if (step) begin
      if (elem_q[KW-1:0] > cand[KW-1:0]) begin
        mem_we_o    = 1'b1;
        mem_waddr_o = hole_m1[AW-1:0];
        mem_wdata_o = cand;
        hole_d      = cpos;
        if (twoc <= cnt_x) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(twoc - 1'b1);
          state_d     = bmhq_pkg::ST_DN_LEFT;
        end else begin
          state_d = bmhq_pkg::ST_PLACE;
        end
      end else begin
        state_d = bmhq_pkg::ST_PLACE;
      end
    end
  end

  assign in_ready_o  = (state_q == bmhq_pkg::ST_IDLE);
  assign res_valid_o = (state_q == bmhq_pkg::ST_DONE);
  assign res_ok_o    = res_ok_q;
  assign res_entry_o = res_q;
  assign count_o     = cnt_q;

  // A read never targets the entry written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o && mem_re_o |-> mem_waddr_o != mem_raddr_o)
    else $error("read and write hit the same heap entry");

  // Count stays within the storage
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W + 1)'(cnt_q) <= (CNT_W + 1)'(DEPTH))
    else $error("entry count beyond depth");

  // Count moves only when an item is taken
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != $past(cnt_q) |-> $past(state_q) == bmhq_pkg::ST_IDLE)
    else $error("entry count changed outside item accept");

  // Enqueue at capacity is refused at once
  a_full_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == bmhq_pkg::ACT_ENQ &&
    CMP_W'(cnt_q) >= eff_cap_i |=> state_q == bmhq_pkg::ST_DONE && !res_ok_q)
    else $error("enqueue on full heap not refused");

endmodule

>>> design/binary_min_heap_queue.sv
// Min-heap priority queue of (key, handle) entries held in one single-port-read
// memory with a registered read. tuser[0] selects enqueue (0) or dequeue (1);
// each item yields one result word. One item is worked at a time: an enqueue
// compares the entry with its parent at each level until it stops rising (no
// compare when the heap was empty) and then places it; a dequeue captures the
// root, fetches the tail entry, compares it at each level with one read per
// child and places it, or ends after the root when it takes out the last entry;
// a refused item goes straight to its result. The result then moves into the
// output register, so the next item is taken while the previous result still
// waits there. The memory serves one read and one write per cycle; the default
// depth is 256.
module binary_min_heap_queue #(
  parameter int unsigned DEPTH       = bmhq_pkg::DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = bmhq_pkg::HANDLE_BITS_DEF,
  localparam int unsigned IN_W  = ((bmhq_pkg::KEY_W + HANDLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W =
    ((bmhq_pkg::KEY_W + HANDLE_BITS + bmhq_pkg::OCC_W + 2 + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // capacity register write
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bmhq_pkg::CAP_W-1:0] cfg_data_i,
  // item stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_W-1:0]           s_axis_tdata,   // key_in, handle_in, zero pad
  input  logic [0:0]                s_axis_tuser,   // action
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_W-1:0]          m_axis_tdata,   // key_out, handle_out, occupancy,
                                                    // is_empty, is_full, zero pad
  output logic [0:0]                m_axis_tuser    // ok
);

  localparam int unsigned KW    = bmhq_pkg::KEY_W;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > bmhq_pkg::CAP_W) ? CNT_W : bmhq_pkg::CAP_W;
  localparam int unsigned DW    = KW + HANDLE_BITS;
  localparam int unsigned USED_W = DW + bmhq_pkg::OCC_W + 2;

  logic [bmhq_pkg::CAP_W-1:0] cap_q;
  logic [CMP_W-1:0]           cap_x;
  logic [CMP_W-1:0]           eff_cap;

  logic                       res_valid;
  logic                       res_ok;
  logic [DW-1:0]              res_entry;
  logic [CNT_W-1:0]           count;
  logic                       out_load;

  logic                       out_valid_q;
  logic                       out_ok_q;
  logic [USED_W-1:0]          out_data_q;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [DW-1:0]              mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [DW-1:0]              mem_rdata;

  // Capacity register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bmhq_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Clamp capacity to the storage depth
  assign cap_x   = CMP_W'(cap_q);
  assign eff_cap = (cap_x > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_x;

  bmhq_ctrl #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser[0]),
    .entry_i     (s_axis_tdata[DW-1:0]),
    .eff_cap_i   (eff_cap),
    .res_valid_o (res_valid),
    .res_ready_i (out_load),
    .res_ok_o    (res_ok),
    .res_entry_o (res_entry),
    .count_o     (count),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bmhq_mem #(
    .DEPTH (DEPTH),
    .DW    (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Advance a finished result when the output register is free or draining
  assign out_load = res_valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ok_q   <= res_ok;
      out_data_q <= {CMP_W'(count) >= eff_cap,
                     count == '0,
                     bmhq_pkg::OCC_W'(count),
                     res_entry};
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tuser[0] = out_ok_q;
  assign m_axis_tdata    = OUT_W'(out_data_q);

endmodule
